[rtl/paged_memory_with_permissions_macros.svh]
// Assertion macros for the paged memory block.
// Included by files that check their own control logic; needs nothing else.
`ifndef PAGED_MEMORY_WITH_PERMISSIONS_MACROS_SVH
`define PAGED_MEMORY_WITH_PERMISSIONS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PMP_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PMP_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pmp_pkg.sv]
// Shared constants, codes and types of the paged memory block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pmp_pkg;

    // Default geometry
    localparam int PAGE_BITS_DEF     = 12;
    localparam int MEM_ADDR_BITS_DEF = 16;

    // Byte lanes of the store
    localparam int LANES = 4;

    // Command codes
    localparam logic [2:0] CMD_READ8   = 3'd0;
    localparam logic [2:0] CMD_READ16  = 3'd1;
    localparam logic [2:0] CMD_READ32  = 3'd2;
    localparam logic [2:0] CMD_WRITE8  = 3'd3;
    localparam logic [2:0] CMD_WRITE16 = 3'd4;
    localparam logic [2:0] CMD_WRITE32 = 3'd5;
    localparam logic [2:0] CMD_FETCH   = 3'd6;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_NO_READ  = 3'd2;
    localparam logic [2:0] ST_NO_WRITE = 3'd3;
    localparam logic [2:0] ST_NO_EXEC  = 3'd4;

    // Page flags: present bit over execute, write, read
    typedef struct packed {
        logic present;
        logic x;
        logic w;
        logic r;
    } flags_t;

endpackage

`default_nettype wire

[rtl/paged_memory_with_permissions.sv]
// Top level of the paged memory: sequencer, lane steering, status checks.
// Depends on pmp_pkg, pmp_byte_bank, pmp_page_table and the macro header.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  command  | start, busy        | cmd, addr, write_data, new_page_perms
//  result   | done (strobe)      | read_data, status
//
// For an item, the flag and byte memories are read in the accept cycle and
// checked, steered and written back in the next. A write that allocates two
// pages passes through S_ALLOC2 for the second flag memory write. done pulses
// in the cycle after the check; the next item may start then unless S_ALLOC2
// follows. After reset a clearing pass zeroes one row of all four byte lanes
// and one flag entry per cycle over all 2**(MEM_ADDR_BITS-2) rows (16384 by
// default), with busy high. The receiver cannot stall; nothing waits on it.
`timescale 1ns / 1ps
`default_nettype none

`include "paged_memory_with_permissions_macros.svh"

module paged_memory_with_permissions #(
    parameter int PAGE_BITS     = pmp_pkg::PAGE_BITS_DEF,
    parameter int MEM_ADDR_BITS = pmp_pkg::MEM_ADDR_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  cmd,
    input  wire logic [31:0] addr,
    input  wire logic [31:0] write_data,
    input  wire logic [2:0]  new_page_perms,
    output logic             done,
    output logic      [31:0] read_data,
    output logic      [2:0]  status
);

    localparam int ROW_W = MEM_ADDR_BITS - 2;
    localparam int IDX_W = (MEM_ADDR_BITS > PAGE_BITS) ? (MEM_ADDR_BITS - PAGE_BITS) : 1;
    localparam int LANES = pmp_pkg::LANES;

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_EXEC   = 2'd2;
    localparam logic [1:0] S_ALLOC2 = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [ROW_W-1:0] clr_row_reg, clr_row_next;

    logic [2:0]       cmd_reg;
    logic [31:0]      addr_reg;
    logic [31:0]      wdata_reg;
    logic [2:0]       perms_reg;
    logic [IDX_W-1:0] page0_reg, page1_reg;
    logic [1:0]       last_off_reg;
    logic             addr_in_store_reg, end_in_store_reg;

    logic             done_reg, done_next;
    logic [31:0]      read_data_reg, read_data_next;
    logic [2:0]       status_reg, status_next;

    logic             accept;
    logic [1:0]       last_off_in;
    logic [32:0]      end_in;
    logic [31:0]      page0_full, page1_full;
    logic [IDX_W-1:0] page0_in, page1_in;
    logic             addr_in_store_in, end_in_store_in;

    logic [31:0]      acc_addr;
    logic [ROW_W-1:0] row_base;
    logic [ROW_W-1:0] bank_row   [LANES];
    logic             bank_we    [LANES];
    logic             bank_en    [LANES];
    logic [7:0]       bank_wdata [LANES];
    logic [7:0]       bank_rdata [LANES];

    pmp_pkg::flags_t  flags0, flags1, wr_flags;
    logic             pt_wr_en;
    logic [IDX_W-1:0] pt_wr_idx;

    logic             is_read, is_fetch, is_write;
    logic             pres0, write_ok, read_ok;
    logic             alloc_first, alloc_second;
    logic [2:0]       exec_status;
    logic [31:0]      exec_data;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign read_data = read_data_reg;
    assign status    = status_reg;

    // Decode the access span from the command
    always_comb
    begin
        case (cmd)
            pmp_pkg::CMD_READ8,  pmp_pkg::CMD_WRITE8:  last_off_in = 2'd0;
            pmp_pkg::CMD_READ16, pmp_pkg::CMD_WRITE16: last_off_in = 2'd1;
            pmp_pkg::CMD_READ32, pmp_pkg::CMD_WRITE32,
            pmp_pkg::CMD_FETCH:                        last_off_in = 2'd3;
            default:                                   last_off_in = 2'd0;
        endcase
    end

    // Locate the first and last byte; addresses do not wrap
    assign end_in           = {1'b0, addr} + {31'd0, last_off_in};
    assign addr_in_store_in = ((addr >> MEM_ADDR_BITS) == 32'd0);
    assign end_in_store_in  = ((end_in >> MEM_ADDR_BITS) == 33'd0);
    assign page0_full       = addr >> PAGE_BITS;
    assign page1_full       = end_in[31:0] >> PAGE_BITS;
    assign page0_in         = page0_full[IDX_W-1:0];
    assign page1_in         = page1_full[IDX_W-1:0];

    // Hold the item while it is checked
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg           <= cmd;
            addr_reg          <= addr;
            wdata_reg         <= write_data;
            perms_reg         <= new_page_perms;
            page0_reg         <= page0_in;
            page1_reg         <= page1_in;
            last_off_reg      <= last_off_in;
            addr_in_store_reg <= addr_in_store_in;
            end_in_store_reg  <= end_in_store_in;
        end
    end

    // Check permissions and presence
    assign is_read  = (cmd_reg == pmp_pkg::CMD_READ8) || (cmd_reg == pmp_pkg::CMD_READ16)
                   || (cmd_reg == pmp_pkg::CMD_READ32);
    assign is_fetch = (cmd_reg == pmp_pkg::CMD_FETCH);
    assign is_write = (cmd_reg == pmp_pkg::CMD_WRITE8) || (cmd_reg == pmp_pkg::CMD_WRITE16)
                   || (cmd_reg == pmp_pkg::CMD_WRITE32);
    assign pres0    = addr_in_store_reg && flags0.present;

    always_comb
    begin
        exec_status = pmp_pkg::ST_INVALID;
        if (is_read || is_fetch)
        begin
            if (!pres0)
            begin
                exec_status = pmp_pkg::ST_INVALID;
            end
            else if (is_fetch && !flags0.x)
            begin
                exec_status = pmp_pkg::ST_NO_EXEC;
            end
            else if (is_read && !flags0.r)
            begin
                exec_status = pmp_pkg::ST_NO_READ;
            end
            else if (!end_in_store_reg || !flags1.present)
            begin
                exec_status = pmp_pkg::ST_INVALID;
            end
            else
            begin
                exec_status = pmp_pkg::ST_OK;
            end
        end
        else if (is_write)
        begin
            if (pres0 && !flags0.w)
            begin
                exec_status = pmp_pkg::ST_NO_WRITE;
            end
            else if (!end_in_store_reg)
            begin
                exec_status = pmp_pkg::ST_INVALID;
            end
            else
            begin
                exec_status = pmp_pkg::ST_OK;
            end
        end
    end

    assign write_ok     = is_write && (exec_status == pmp_pkg::ST_OK);
    assign read_ok      = (is_read || is_fetch) && (exec_status == pmp_pkg::ST_OK);
    assign alloc_first  = !flags0.present;
    assign alloc_second = !flags1.present && (page1_reg != page0_reg);

    // Gather the bytes of a read, lowest address first
    always_comb
    begin
        logic [1:0] lane;
        exec_data = 32'd0;
        for (int i = 0; i < LANES; i++)
        begin
            lane = addr_reg[1:0] + 2'(i);
            if (read_ok && (2'(i) <= last_off_reg))
            begin
                exec_data[8*i +: 8] = bank_rdata[lane];
            end
        end
    end

    // Steer the lanes: clearing pass, accept-cycle read or write-back
    assign acc_addr = (state_reg == S_IDLE) ? addr : addr_reg;
    assign row_base = acc_addr[ROW_W+1:2];

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        logic       wrap;
        logic [1:0] byte_idx;

        assign wrap     = (2'(k) < acc_addr[1:0]);
        assign byte_idx = 2'(k) - addr_reg[1:0];

        always_comb
        begin
            if (state_reg == S_CLEAR)
            begin
                bank_row[k]   = clr_row_reg;
                bank_we[k]    = 1'b1;
                bank_wdata[k] = 8'd0;
            end
            else
            begin
                bank_row[k]   = row_base + {{(ROW_W-1){1'b0}}, wrap};
                bank_we[k]    = (state_reg == S_EXEC) && write_ok
                             && (byte_idx <= last_off_reg);
                bank_wdata[k] = wdata_reg[8*byte_idx +: 8];
            end
            bank_en[k] = accept || bank_we[k];
        end

        pmp_byte_bank #(
            .ROW_W (ROW_W)
        ) u_bank (
            .clk   (clk),
            .en    (bank_en[k]),
            .we    (bank_we[k]),
            .row   (bank_row[k]),
            .wdata (bank_wdata[k]),
            .rdata (bank_rdata[k])
        );
    end

    // Write page flags: clear, or allocate first then second page
    always_comb
    begin
        pt_wr_en  = 1'b0;
        pt_wr_idx = page0_reg;
        wr_flags  = '{present: 1'b1, x: perms_reg[2], w: perms_reg[1], r: perms_reg[0]};
        case (state_reg)
            S_CLEAR:
            begin
                pt_wr_en  = 1'b1;
                pt_wr_idx = clr_row_reg[IDX_W-1:0];
                wr_flags  = '0;
            end
            S_EXEC:
            begin
                pt_wr_en  = write_ok && (alloc_first || alloc_second);
                pt_wr_idx = alloc_first ? page0_reg : page1_reg;
            end
            S_ALLOC2:
            begin
                pt_wr_en  = 1'b1;
                pt_wr_idx = page1_reg;
            end
            default:
            begin
                pt_wr_en = 1'b0;
            end
        endcase
    end

    pmp_page_table #(
        .IDX_W (IDX_W)
    ) u_page_table (
        .clk       (clk),
        .rd_en     (accept),
        .rd_idx0   (page0_in),
        .rd_idx1   (page1_in),
        .rd_flags0 (flags0),
        .rd_flags1 (flags1),
        .wr_en     (pt_wr_en),
        .wr_idx    (pt_wr_idx),
        .wr_flags  (wr_flags)
    );

    // Advance the sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_row_next = clr_row_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_row_next = clr_row_reg + {{(ROW_W-1){1'b0}}, 1'b1};
                if (&clr_row_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (write_ok && alloc_first && alloc_second)
                begin
                    state_next = S_ALLOC2;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ALLOC2:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Form the result item
    assign done_next      = (state_reg == S_EXEC);
    assign read_data_next = exec_data;
    assign status_next    = exec_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_row_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_row_reg <= clr_row_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            read_data_reg <= read_data_next;
            status_reg    <= status_next;
        end
    end

    // Checks
    `PMP_ASSERT_NXT(a_exec_gives_done, clk, rst_n, state_reg == S_EXEC, done_reg,
        "check cycle not followed by result strobe")
    `PMP_ASSERT_IMP(a_fail_zero_data, clk, rst_n,
        done_reg && (status_reg != pmp_pkg::ST_OK), read_data_reg == 32'd0,
        "failed access returned data")
    `PMP_ASSERT_IMP(a_write_only_ok, clk, rst_n,
        (state_reg == S_EXEC) && bank_we[0], exec_status == pmp_pkg::ST_OK,
        "byte store written by a refused access")
    `PMP_ASSERT_IMP(a_alloc2_after_exec, clk, rst_n, state_reg == S_ALLOC2,
        $past(state_reg) == S_EXEC, "second allocation outside a write")

endmodule

`default_nettype wire

[rtl/pmp_byte_bank.sv]
// One byte lane of the data store: synchronous RAM, one port, read-first.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module pmp_byte_bank #(
    parameter int ROW_W = 14
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic             we,
    input  wire logic [ROW_W-1:0] row,
    input  wire logic [7:0]       wdata,
    output logic      [7:0]       rdata
);

    logic [7:0] mem [2**ROW_W];

    // Access the row; read data is registered
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[row] <= wdata;
            end
            rdata <= mem[row];
        end
    end

endmodule

`default_nettype wire

[rtl/pmp_page_table.sv]
// Page flag memory: two registered read ports, one write port.
// Depends on pmp_pkg for the flag type.
`timescale 1ns / 1ps
`default_nettype none

module pmp_page_table #(
    parameter int IDX_W = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rd_en,
    input  wire logic [IDX_W-1:0]     rd_idx0,
    input  wire logic [IDX_W-1:0]     rd_idx1,
    output pmp_pkg::flags_t           rd_flags0,
    output pmp_pkg::flags_t           rd_flags1,
    input  wire logic                 wr_en,
    input  wire logic [IDX_W-1:0]     wr_idx,
    input  wire pmp_pkg::flags_t      wr_flags
);

    pmp_pkg::flags_t mem [2**IDX_W];

    // Write the flags of one page
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_flags;
        end
    end

    // Read both pages of an access
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_flags0 <= mem[rd_idx0];
            rd_flags1 <= mem[rd_idx1];
        end
    end

endmodule

`default_nettype wire

[verif/tb_paged_memory_with_permissions.sv]
// Testbench for the paged memory with page permissions: directed and random accesses,
// checked against an in-bench model of pages, permissions and bytes.
// Depends on pmp_pkg and the paged_memory_with_permissions top level.
`timescale 1ns / 1ps

module tb_paged_memory_with_permissions;

    localparam int PAGE_BITS     = pmp_pkg::PAGE_BITS_DEF;
    localparam int MEM_ADDR_BITS = pmp_pkg::MEM_ADDR_BITS_DEF;
    localparam int MEM_SIZE      = 1 << MEM_ADDR_BITS;
    localparam int PAGE_BYTES    = 1 << PAGE_BITS;
    localparam int NUM_PAGES     = (MEM_ADDR_BITS > PAGE_BITS) ?
                                   (1 << (MEM_ADDR_BITS - PAGE_BITS)) : 1;

    // Command code that the block does not define
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    // Random part: writes stay on low pages for a while so high pages stay missing
    localparam int RANDOM_ITEMS   = 1230;
    localparam int EARLY_ITEMS    = 800;
    localparam int LOW_WRITE_PAGE = 10;
    localparam int CALM_FIRST     = 300;
    localparam int CALM_LAST      = 549;

    // Longest quiet stretch: clearing pass after reset, taken several times over
    localparam int QUIET_LIMIT = 80000;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] where;
        logic [31:0] data;
        logic [2:0]  st;
    } response_t;

    // Model of the memory and queue of responses still owed by the block
    class access_checker;
        pmp_pkg::flags_t page_flags [NUM_PAGES];
        logic [7:0]      mem_bytes [MEM_SIZE];
        response_t       owed [$];
        int              errors;
        int              results;
        int              status_seen [5];

        function new();
            foreach (page_flags[i])
                page_flags[i] = '0;
            foreach (mem_bytes[i])
                mem_bytes[i] = 8'h00;
            foreach (status_seen[i])
                status_seen[i] = 0;
            errors  = 0;
            results = 0;
        endfunction

        function bit in_store(logic [32:0] a);
            return a < MEM_SIZE;
        endfunction

        function int page_of(logic [32:0] a);
            return int'(a >> PAGE_BITS) % NUM_PAGES;
        endfunction

        function bit present_at(logic [32:0] a);
            return in_store(a) && page_flags[page_of(a)].present;
        endfunction

        // Apply one access to the model and return what the block must answer
        function response_t predict_access(logic [2:0] c, logic [31:0] a, logic [31:0] d,
                                           logic [2:0] perms);
            response_t   rsp;
            int          nbytes;
            int          p;
            int          base;
            int          len;
            logic [32:0] ba;

            rsp.op    = c;
            rsp.where = a;
            rsp.data  = '0;
            rsp.st    = pmp_pkg::ST_OK;
            if (c == CMD_UNUSED)
            begin
                rsp.st = pmp_pkg::ST_INVALID;
            end
            else if (c == pmp_pkg::CMD_READ8 || c == pmp_pkg::CMD_READ16
                     || c == pmp_pkg::CMD_READ32 || c == pmp_pkg::CMD_FETCH)
            begin
                nbytes = (c == pmp_pkg::CMD_FETCH) ? 4 : (1 << c);
                if (!present_at({1'b0, a}))
                    rsp.st = pmp_pkg::ST_INVALID;
                else if (c == pmp_pkg::CMD_FETCH && !page_flags[page_of({1'b0, a})].x)
                    rsp.st = pmp_pkg::ST_NO_EXEC;
                else if (c != pmp_pkg::CMD_FETCH && !page_flags[page_of({1'b0, a})].r)
                    rsp.st = pmp_pkg::ST_NO_READ;
                else
                begin
                    // Only the first page is checked; later bytes just need a present page
                    for (int i = 0; i < nbytes; i++)
                    begin
                        ba = {1'b0, a} + 33'(i);
                        if (!present_at(ba))
                        begin
                            rsp.st   = pmp_pkg::ST_INVALID;
                            rsp.data = '0;
                            break;
                        end
                        rsp.data[8*i +: 8] = mem_bytes[int'(ba)];
                    end
                end
            end
            else
            begin
                nbytes = 1 << (c - pmp_pkg::CMD_WRITE8);
                if (present_at({1'b0, a}) && !page_flags[page_of({1'b0, a})].w)
                    rsp.st = pmp_pkg::ST_NO_WRITE;
                else if (!in_store({1'b0, a} + 33'(nbytes - 1)))
                    rsp.st = pmp_pkg::ST_INVALID;
                else
                begin
                    for (int i = 0; i < nbytes; i++)
                    begin
                        ba = {1'b0, a} + 33'(i);
                        p  = page_of(ba);
                        // Allocate a missing page as zeros with the item's permissions
                        if (!page_flags[p].present)
                        begin
                            base = p << PAGE_BITS;
                            len  = PAGE_BYTES;
                            if (len > MEM_SIZE - base)
                                len = MEM_SIZE - base;
                            for (int j = 0; j < len; j++)
                                mem_bytes[base + j] = 8'h00;
                            page_flags[p] = pmp_pkg::flags_t'({1'b1, perms});
                        end
                        mem_bytes[int'(ba)] = d[8*i +: 8];
                    end
                end
            end
            return rsp;
        endfunction

        function void note_access(logic [2:0] c, logic [31:0] a, logic [31:0] d,
                                  logic [2:0] perms);
            owed.push_back(predict_access(c, a, d, perms));
        endfunction

        function void check_response(logic [31:0] data, logic [2:0] st);
            response_t want;

            results++;
            if (st < 5)
                status_seen[st]++;
            if (owed.size() == 0)
            begin
                $display("%0t: result with none owed: data %08h status %0d", $time, data, st);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (data !== want.data)
            begin
                $display("%0t: cmd %0d addr %08h read_data expected %08h actual %08h",
                         $time, want.op, want.where, want.data, data);
                errors++;
            end
            if (st !== want.st)
            begin
                $display("%0t: cmd %0d addr %08h status expected %0d actual %0d",
                         $time, want.op, want.where, want.st, st);
                errors++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        start          = 1'b0;
    logic [2:0]  cmd            = '0;
    logic [31:0] addr           = '0;
    logic [31:0] write_data     = '0;
    logic [2:0]  new_page_perms = '0;
    logic        busy;
    logic        done;
    logic [31:0] read_data;
    logic [2:0]  status;

    access_checker sb = new();
    bit            idle_enabled = 1'b1;
    int            items_sent   = 0;
    int            quiet_cycles = 0;

    paged_memory_with_permissions #(
        .PAGE_BITS     (PAGE_BITS),
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .addr           (addr),
        .write_data     (write_data),
        .new_page_perms (new_page_perms),
        .done           (done),
        .read_data      (read_data),
        .status         (status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Check results and watch for a stalled run
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_response(read_data, status);
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: watchdog: no item or result for %0d cycles", $time, quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Present one item, hold it until accepted, then record the expected response
    task automatic send_access(input logic [2:0] c, input logic [31:0] a,
                               input logic [31:0] d, input logic [2:0] perms);
        if (idle_enabled)
            while ($urandom_range(0, 99) < 22)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        @(negedge clk);
        cmd            <= c;
        addr           <= a;
        write_data     <= d;
        new_page_perms <= perms;
        start          <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_access(c, a, d, perms);
        items_sent++;
    endtask

    // Build one random access; early on, writes leave the high pages missing
    task automatic random_access(input bit early);
        logic [2:0]  c;
        logic [31:0] a;
        int          pick;
        int          pg;
        bit          is_write;

        pick = $urandom_range(0, 99);
        if (pick < 40)
            c = pmp_pkg::CMD_WRITE8 + 3'($urandom_range(0, 2));
        else if (pick < 75)
            c = pmp_pkg::CMD_READ8 + 3'($urandom_range(0, 2));
        else if (pick < 97)
            c = pmp_pkg::CMD_FETCH;
        else
            c = CMD_UNUSED;
        is_write = (c == pmp_pkg::CMD_WRITE8 || c == pmp_pkg::CMD_WRITE16
                    || c == pmp_pkg::CMD_WRITE32);

        pick = $urandom_range(0, 99);
        pg   = $urandom_range(0, NUM_PAGES - 1);
        if (early && is_write && pg > LOW_WRITE_PAGE)
            pg = $urandom_range(1, LOW_WRITE_PAGE);
        if (pick < 8)
            a = $urandom;
        else if (pick < 12 && !(early && is_write))
            a = 32'(MEM_SIZE - 4 + $urandom_range(0, 7));
        else if (pick < 45)
            a = 32'(pg * PAGE_BYTES + PAGE_BYTES - 4 + $urandom_range(0, 7));
        else if (pick < 75)
            a = 32'(pg * PAGE_BYTES + $urandom_range(0, 63));
        else
            a = 32'(pg * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
        send_access(c, a, $urandom, 3'($urandom_range(0, 7)));
    endtask

    initial
    begin
        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;

        // Missing pages, then a page with no permissions at all
        send_access(pmp_pkg::CMD_READ8,   32'h0000_0000, 32'h0,         3'b000);
        send_access(pmp_pkg::CMD_FETCH,   32'h0000_0000, 32'h0,         3'b000);
        send_access(pmp_pkg::CMD_WRITE8,  32'h0000_0000, 32'h0000_00A5, 3'b000);
        send_access(pmp_pkg::CMD_READ8,   32'h0000_0000, 32'h0,         3'b000);
        send_access(pmp_pkg::CMD_FETCH,   32'h0000_0000, 32'h0,         3'b000);
        send_access(pmp_pkg::CMD_WRITE16, 32'h0000_0000, 32'h0000_1234, 3'b111);
        send_access(pmp_pkg::CMD_WRITE16, 32'h0000_0FFF, 32'h0000_5678, 3'b111);
        // Write that allocates two pages, then read and fetch across them
        send_access(pmp_pkg::CMD_WRITE32, 32'h0000_1FFE, 32'hDEAD_BEEF, 3'b111);
        send_access(pmp_pkg::CMD_READ32,  32'h0000_1FFE, 32'h0,         3'b000);
        send_access(pmp_pkg::CMD_FETCH,   32'h0000_1FFE, 32'h0,         3'b000);
        send_access(pmp_pkg::CMD_READ16,  32'h0000_1FFF, 32'h0,         3'b000);
        // Present first page allocating a missing second one
        send_access(pmp_pkg::CMD_WRITE32, 32'h0000_2FFF, 32'h0102_0304, 3'b011);
        send_access(pmp_pkg::CMD_FETCH,   32'h0000_3000, 32'h0,         3'b000);
        send_access(pmp_pkg::CMD_READ32,  32'h0000_2FFF, 32'h0,         3'b000);
        // Read that runs into a missing second page
        send_access(pmp_pkg::CMD_READ32,  32'h0000_3FFE, 32'h0,         3'b000);
        // Top of the store and beyond it
        send_access(pmp_pkg::CMD_WRITE32, 32'h0000_FFFE, 32'hFFFF_FFFF, 3'b111);
        send_access(pmp_pkg::CMD_WRITE8,  32'h0000_FFFF, 32'hFFFF_FF7E, 3'b111);
        send_access(pmp_pkg::CMD_READ16,  32'h0000_FFFF, 32'h0,         3'b000);
        send_access(pmp_pkg::CMD_READ8,   32'h0000_FFFF, 32'h0,         3'b000);
        send_access(pmp_pkg::CMD_WRITE32, 32'h0000_FFFC, 32'hFFFF_FFFF, 3'b000);
        send_access(pmp_pkg::CMD_READ32,  32'h0000_FFFC, 32'h0,         3'b000);
        send_access(pmp_pkg::CMD_READ32,  32'hFFFF_FFFF, 32'h0,         3'b000);
        send_access(pmp_pkg::CMD_WRITE8,  32'h0001_0000, 32'h0000_0011, 3'b111);
        send_access(pmp_pkg::CMD_FETCH,   32'hFFFF_FFFC, 32'h0,         3'b000);
        send_access(CMD_UNUSED,           32'h0000_1FFE, 32'hFFFF_FFFF, 3'b111);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            idle_enabled = !(n >= CALM_FIRST && n <= CALM_LAST);
            random_access(n < EARLY_ITEMS);
        end

        // Drop start so the last item is not taken again, then drain
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);

        $display("Sent %0d accesses, checked %0d results", items_sent, sb.results);
        $display("Status seen: ok %0d, invalid %0d, no-read %0d, no-write %0d, no-exec %0d",
                 sb.status_seen[pmp_pkg::ST_OK], sb.status_seen[pmp_pkg::ST_INVALID],
                 sb.status_seen[pmp_pkg::ST_NO_READ], sb.status_seen[pmp_pkg::ST_NO_WRITE],
                 sb.status_seen[pmp_pkg::ST_NO_EXEC]);
        if (sb.pending() != 0)
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
